// ----- hdl/ogh_pkg.sv -----
// Shared types and constants of the occupancy grid hit counter.
// No dependencies; compiled first.
package ogh_pkg;

	localparam int COORD_W = 24;   // signed Q16.8 metres
	localparam int RES_W   = 16;   // unsigned Q8.8 cells per metre
	localparam int FRAC_W  = 16;   // fraction bits of coord * resolution
	localparam int PROD_W  = COORD_W + RES_W;
	localparam int QUO_W   = PROD_W - FRAC_W;
	localparam int SIZE_W  = 10;   // columns/rows in use, query coordinates
	localparam int MAX_SIZE = (1 << SIZE_W) - 1;
	localparam int THR_W   = 16;
	localparam int COST_W  = 17;
	localparam int POS_W   = 11;
	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int NB_COUNT = 8;
	localparam int NB_W = 3;
	localparam logic [NB_W-1:0] NB_LAST = NB_W'(NB_COUNT - 1);

	// neighbour offsets, clockwise from upper-left
	localparam logic signed [1:0] NB_DCOL [NB_COUNT] =
		'{-2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1};
	localparam logic signed [1:0] NB_DROW [NB_COUNT] =
		'{-2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0};

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_AUTO_ENABLE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HIT_THRESHOLD = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INV_RES       = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COLUMNS       = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ROWS          = 3'd4;

	localparam logic              RST_AUTO_ENABLE   = 1'b0;
	localparam logic [THR_W-1:0]  RST_HIT_THRESHOLD = 16'd200;
	localparam logic [RES_W-1:0]  RST_INV_RES       = 16'd1280;
	localparam logic [SIZE_W-1:0] RST_COLUMNS       = 10'd500;
	localparam logic [SIZE_W-1:0] RST_ROWS          = 10'd500;

	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// one scaled axis: cell index and whether it lies inside the grid
	typedef struct packed {
		logic              hit;
		logic [SIZE_W-1:0] idx;
	} axis_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RANGE,
		S_LOOKUP,
		S_UPDATE,
		S_QCHECK,
		S_NREAD,
		S_NSEND
	} state_t;

endpackage

// ----- hdl/ogh_if.sv -----
// Channel interfaces of the occupancy grid hit counter: items in, results out,
// configuration writes. Depends on ogh_pkg.
interface ogh_in_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic signed [ogh_pkg::COORD_W-1:0]  point_x;
	logic signed [ogh_pkg::COORD_W-1:0]  point_y;
	logic [ogh_pkg::SIZE_W-1:0]          query_column;
	logic [ogh_pkg::SIZE_W-1:0]          query_row;

	modport source (output valid, kind, point_x, point_y, query_column, query_row,
		input ready);
	modport sink (input valid, kind, point_x, point_y, query_column, query_row,
		output ready);
endinterface

interface ogh_out_if;
	logic                               valid;
	logic                               ready;
	logic                               query_ok;
	logic signed [ogh_pkg::COST_W-1:0]  neighbour_cost;
	logic signed [ogh_pkg::POS_W-1:0]   neighbour_column;
	logic signed [ogh_pkg::POS_W-1:0]   neighbour_row;
	logic                               last_of_run;

	modport source (output valid, query_ok, neighbour_cost, neighbour_column,
		neighbour_row, last_of_run, input ready);
	modport sink (input valid, query_ok, neighbour_cost, neighbour_column,
		neighbour_row, last_of_run, output ready);
endinterface

interface ogh_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [ogh_pkg::REG_IDX_W-1:0]       index;
	logic [ogh_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/occupancy_grid_hit_counter.sv -----
// Occupancy grid hit counter: a point request raises its cell's hit count up to
// a threshold; a query request returns the counts of the eight neighbours of a
// cell, clockwise from upper-left. The counts live in one synchronous memory of
// GRID_ROWS*GRID_COLUMNS entries with a registered read. After reset a clearing
// pass writes zero to every entry, one a cycle; no request is taken until it is
// done, configuration writes are. One request is handled at a time. A point
// request goes from acceptance through scale, range check, read and write back
// before the next acceptance, and skips the read and write back when it is
// dropped because points are disabled or it falls off the grid. A query inside
// the grid reads and sends the neighbours one by one, waiting while results are
// stalled; a query outside the grid sends one result, held while it is stalled.
// The read-modify-write of a point ends before the next request can read, so no
// forwarding path is needed.
// Depends on ogh_pkg, ogh_if and ogh_scale.
module occupancy_grid_hit_counter #(
	parameter int GRID_COLUMNS = 512,
	parameter int GRID_ROWS    = 512,
	parameter int COUNT_BITS   = 16
) (
	input logic       clk,
	input logic       arst_n,
	ogh_cfg_if.sink   cfg,
	ogh_in_if.sink    item,
	ogh_out_if.source result
);
	import ogh_pkg::*;

	localparam int DEPTH = GRID_ROWS * GRID_COLUMNS;
	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] COLS_A = AW'(GRID_COLUMNS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam int COL_CAP = (GRID_COLUMNS > MAX_SIZE) ? MAX_SIZE : GRID_COLUMNS;
	localparam int ROW_CAP = (GRID_ROWS > MAX_SIZE) ? MAX_SIZE : GRID_ROWS;
	localparam logic [THR_W-1:0] CNT_CAP = THR_W'((1 << COUNT_BITS) - 1);

	function automatic logic [AW-1:0] cell_addr(input logic [SIZE_W-1:0] col,
		input logic [SIZE_W-1:0] row);
		return AW'(row) * COLS_A + AW'(col);
	endfunction

	// configuration
	logic              cfg_en_q;
	logic [THR_W-1:0]  cfg_thr_q;
	logic [RES_W-1:0]  cfg_res_q;
	logic [SIZE_W-1:0] cfg_cols_q;
	logic [SIZE_W-1:0] cfg_rows_q;

	logic [SIZE_W-1:0] col_lim;
	logic [SIZE_W-1:0] row_lim;
	logic [THR_W-1:0]  thr_cap;

	// control
	state_t            state_q, state_d;
	logic [NB_W-1:0]   k_q, k_d;
	logic              clr_active_q;
	logic [AW-1:0]     clr_addr_q;
	logic              in_fire;

	// query
	logic [SIZE_W-1:0]       qc_q, qr_q;
	logic                    q_inside;
	logic signed [POS_W-1:0] nb_col, nb_row;
	logic                    nb_hit;
	logic                    nb_hit_s1;
	logic signed [POS_W-1:0] nb_col_s1, nb_row_s1;
	logic                    nb_load;

	// points
	axis_t             ax_s2, ay_s2;
	logic [AW-1:0]     pt_addr;
	logic              sat_ok;
	logic              upd_we;

	// memory
	logic [COUNT_BITS-1:0] mem [DEPTH];
	logic [COUNT_BITS-1:0] rdata_q;
	logic                  mem_re, mem_we;
	logic [AW-1:0]         mem_raddr, mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;

	// result register
	logic                    out_valid_q;
	logic                    res_ok_q, res_last_q;
	logic signed [COST_W-1:0] res_cost_q;
	logic signed [POS_W-1:0]  res_col_q, res_row_q;
	logic                    out_free, out_load;
	logic                    out_ok, out_last;
	logic signed [COST_W-1:0] out_cost;
	logic signed [POS_W-1:0]  out_col, out_row;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_en_q   <= RST_AUTO_ENABLE;
			cfg_thr_q  <= RST_HIT_THRESHOLD;
			cfg_res_q  <= RST_INV_RES;
			cfg_cols_q <= RST_COLUMNS;
			cfg_rows_q <= RST_ROWS;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_AUTO_ENABLE:   cfg_en_q   <= cfg.data[0];
				REG_HIT_THRESHOLD: cfg_thr_q  <= cfg.data[THR_W-1:0];
				REG_INV_RES:       cfg_res_q  <= cfg.data[RES_W-1:0];
				REG_COLUMNS:       cfg_cols_q <= cfg.data[SIZE_W-1:0];
				REG_ROWS:          cfg_rows_q <= cfg.data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		col_lim = (cfg_cols_q > SIZE_W'(COL_CAP)) ? SIZE_W'(COL_CAP) : cfg_cols_q;
		row_lim = (cfg_rows_q > SIZE_W'(ROW_CAP)) ? SIZE_W'(ROW_CAP) : cfg_rows_q;
		thr_cap = (cfg_thr_q > CNT_CAP) ? CNT_CAP : cfg_thr_q;
	end

	assign item.ready = (state_q == S_IDLE) && !clr_active_q;
	assign in_fire = item.valid && item.ready;

	ogh_scale u_scale_x (
		.clk     (clk),
		.load    (in_fire),
		.coord   (item.point_x),
		.inv_res (cfg_res_q),
		.limit   (col_lim),
		.axis_s2 (ax_s2)
	);

	ogh_scale u_scale_y (
		.clk     (clk),
		.load    (in_fire),
		.coord   (item.point_y),
		.inv_res (cfg_res_q),
		.limit   (row_lim),
		.axis_s2 (ay_s2)
	);

	always_comb begin
		pt_addr  = cell_addr(ax_s2.idx, ay_s2.idx);
		sat_ok   = THR_W'(rdata_q) < thr_cap;
		q_inside = (qc_q < col_lim) && (qr_q < row_lim);
		// qc_q < col_lim <= 1023 whenever neighbours are walked, so no overflow
		nb_col = POS_W'($signed({1'b0, qc_q})) + POS_W'(NB_DCOL[k_q]);
		nb_row = POS_W'($signed({1'b0, qr_q})) + POS_W'(NB_DROW[k_q]);
		nb_hit = !nb_col[POS_W-1] && (nb_col[SIZE_W-1:0] < col_lim)
			&& !nb_row[POS_W-1] && (nb_row[SIZE_W-1:0] < row_lim);
		out_free = !out_valid_q || result.ready;
	end

	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		mem_re    = 1'b0;
		mem_raddr = pt_addr;
		upd_we    = 1'b0;
		nb_load   = 1'b0;
		out_load  = 1'b0;
		out_ok    = 1'b1;
		out_cost  = '1;
		out_col   = '1;
		out_row   = '1;
		out_last  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_d = (item.kind == KIND_QUERY) ? S_QCHECK : S_RANGE;
				end
			end
			S_RANGE: state_d = S_LOOKUP;
			S_LOOKUP: begin
				if (cfg_en_q && ax_s2.hit && ay_s2.hit) begin
					mem_re  = 1'b1;
					state_d = S_UPDATE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_UPDATE: begin
				upd_we  = sat_ok;
				state_d = S_IDLE;
			end
			S_QCHECK: begin
				k_d = '0;
				if (q_inside) begin
					state_d = S_NREAD;
				end else if (out_free) begin
					out_load = 1'b1;
					out_ok   = 1'b0;
					out_last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_NREAD: begin
				nb_load   = 1'b1;
				mem_re    = nb_hit;
				mem_raddr = cell_addr(nb_col[SIZE_W-1:0], nb_row[SIZE_W-1:0]);
				state_d   = S_NSEND;
			end
			S_NSEND: begin
				if (out_free) begin
					out_load = 1'b1;
					out_last = (k_q == NB_LAST);
					if (nb_hit_s1) begin
						out_cost = COST_W'(rdata_q);
						out_col  = nb_col_s1;
						out_row  = nb_row_s1;
					end
					k_d     = k_q + 1'b1;
					state_d = (k_q == NB_LAST) ? S_IDLE : S_NREAD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			k_q          <= '0;
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			if (clr_active_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == LAST_ADDR) begin
					clr_active_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			qc_q <= item.query_column;
			qr_q <= item.query_row;
		end
		if (nb_load) begin
			nb_hit_s1 <= nb_hit;
			nb_col_s1 <= nb_col;
			nb_row_s1 <= nb_row;
		end
		if (out_load) begin
			res_ok_q   <= out_ok;
			res_cost_q <= out_cost;
			res_col_q  <= out_col;
			res_row_q  <= out_row;
			res_last_q <= out_last;
		end
	end

	// single write port shared by the clearing pass and the point update
	always_comb begin
		mem_we    = clr_active_q || upd_we;
		mem_waddr = clr_active_q ? clr_addr_q : pt_addr;
		mem_wdata = clr_active_q ? '0 : rdata_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	assign result.valid            = out_valid_q;
	assign result.query_ok         = res_ok_q;
	assign result.neighbour_cost   = res_cost_q;
	assign result.neighbour_column = res_col_q;
	assign result.neighbour_row    = res_row_q;
	assign result.last_of_run      = res_last_q;

`ifndef NO_ASSERTIONS
	a_no_request_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !item.ready)
		else $error("request accepted during clearing pass");

	a_clear_covers_memory: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_active_q) |-> $past(clr_addr_q) == LAST_ADDR)
		else $error("clearing pass ended early");

	a_no_same_cycle_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && mem_waddr == mem_raddr))
		else $error("read and write of one entry in the same cycle");

	a_count_within_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !clr_active_q) |-> THR_W'(mem_wdata) <= thr_cap)
		else $error("hit count raised past threshold");

	a_off_grid_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((res_cost_q == -1) == (res_col_q == -1))
			&& ((res_col_q == -1) == (res_row_q == -1)))
		else $error("off-grid neighbour marked inconsistently");
`endif

endmodule

// ----- hdl/ogh_scale.sv -----
// Scales one signed Q16.8 coordinate by the Q8.8 resolution into a cell index,
// truncating toward zero, and tests it against the size in use. Depends on ogh_pkg.
module ogh_scale (
	input  logic                               clk,
	input  logic                               load,
	input  logic signed [ogh_pkg::COORD_W-1:0] coord,
	input  logic [ogh_pkg::RES_W-1:0]          inv_res,
	input  logic [ogh_pkg::SIZE_W-1:0]         limit,
	output ogh_pkg::axis_t                     axis_s2
);
	import ogh_pkg::*;

	logic signed [PROD_W-1:0] product_s1;
	logic                     neg;
	logic [PROD_W-1:0]        mag;
	logic [QUO_W-1:0]         quo;
	logic                     hit;

	always_ff @(posedge clk) begin
		if (load) begin
			product_s1 <= PROD_W'(coord) * PROD_W'($signed({1'b0, inv_res}));
		end
	end

	// A negative product only lands inside when it truncates to zero.
	always_comb begin
		neg = product_s1[PROD_W-1];
		mag = neg ? PROD_W'(-product_s1) : PROD_W'(product_s1);
		quo = mag[PROD_W-1:FRAC_W];
		hit = (!neg || quo == '0) && (quo < QUO_W'(limit));
	end

	always_ff @(posedge clk) begin
		axis_s2.hit <= hit;
		axis_s2.idx <= quo[SIZE_W-1:0];
	end

endmodule
